// File: sv/iss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed sequence store package
// Shared sizes, action and status codes, and the transfer payload types.
// ----------------------------------------------------------------------------
package iss_pkg;

   localparam int DEPTH          = 16;
   localparam int DATA_WIDTH_DEF = 32;
   localparam int IDX_W          = $clog2(DEPTH);
   localparam int CNT_W          = $clog2(DEPTH + 1);

   localparam logic [2:0] ACT_APPEND  = 3'd0;
   localparam logic [2:0] ACT_PREPEND = 3'd1;
   localparam logic [2:0] ACT_INSERT  = 3'd2;
   localparam logic [2:0] ACT_REMOVE  = 3'd3;
   localparam logic [2:0] ACT_READ    = 3'd4;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_BOUNDS = 2'd1;
   localparam logic [1:0] ST_FULL   = 2'd2;

   typedef struct packed {
      logic [2:0]         action;
      logic [4:0]         position;
      logic signed [31:0] word_in;
   } req_type;

   typedef struct packed {
      logic signed [31:0] word_out;
      logic [1:0]         status;
      logic [4:0]         length;
   } rsp_type;

   typedef struct packed {
      logic             ins;
      logic             del;
      logic [IDX_W-1:0] idx;
   } iss_cmd_type;

endpackage

// File: sv/iss_entries.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed sequence store entries
// Entry registers with parallel open-slot and close-slot shifting and a read
// port.
// ----------------------------------------------------------------------------
module iss_entries #(
   parameter int DATA_WIDTH = iss_pkg::DATA_WIDTH_DEF
) (
   input  logic                          clock,
   input  iss_pkg::iss_cmd_type          cmd,
   input  logic [DATA_WIDTH-1:0]         wr_word,
   input  logic [iss_pkg::IDX_W-1:0]     rd_idx,
   output logic [DATA_WIDTH-1:0]         rd_word
);
   import iss_pkg::*;

   logic [DATA_WIDTH-1:0] ent_ff [DEPTH];
   logic [DATA_WIDTH-1:0] ent_in [DEPTH];

   for (genvar g = 0; g < DEPTH; g++) begin : g_ent
      logic below;
      logic at;
      assign below = IDX_W'(g) < cmd.idx;
      assign at    = IDX_W'(g) == cmd.idx;

      always_comb begin
         ent_in[g] = ent_ff[g];
         if (cmd.ins && !below) begin
            if (at) begin
               ent_in[g] = wr_word;
            end else begin
               if (g > 0) begin
                  ent_in[g] = ent_ff[(g > 0) ? g - 1 : 0];
               end
            end
         end else if (cmd.del && !below) begin
            if (g < DEPTH - 1) begin
               ent_in[g] = ent_ff[(g < DEPTH - 1) ? g + 1 : g];
            end
         end
      end

      always_ff @(posedge clock) begin
         ent_ff[g] <= ent_in[g];
      end
   end

   assign rd_word = ent_ff[rd_idx];

endmodule

// File: sv/indexed_sequence_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed sequence store
// Ordered sequence of up to DEPTH words with append, prepend, insert, remove
// and read by position; one response per request.
// ----------------------------------------------------------------------------
//   channel   ports                          direction
//   request   req_valid req_stall req_data   in  (action, position, word_in)
//   response  rsp_valid rsp_stall rsp_data   out (word_out, status, length)
//
// One request per cycle sustained while rsp_stall is low; a request passes the
// input register, then the response register, before its response is valid.
// All entries shift in parallel in the cycle the request leaves the input
// register, so the next request sees the updated sequence.
// Reset clears the entry count and both valid flags; entry contents are
// undefined until written.
// A stalled response holds the request in the input register.
// ----------------------------------------------------------------------------
module indexed_sequence_store #(
   parameter int DATA_WIDTH = iss_pkg::DATA_WIDTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  iss_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output iss_pkg::rsp_type rsp_data
);
   import iss_pkg::*;

   logic             v1_ff, v1_in;
   req_type          r1_ff;
   logic             v2_ff, v2_in;
   rsp_type          r2_ff, r2_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic                  adv;
   logic                  full;
   logic                  in_ins_range;
   logic                  in_rd_range;
   logic                  rd_ok;
   logic [1:0]            status;
   iss_cmd_type           cmd;
   logic [63:0]           wide_in;
   logic [DATA_WIDTH-1:0] wr_word;
   logic [DATA_WIDTH-1:0] rd_word;
   logic signed [63:0]    rd_wide;

   assign adv       = v1_ff && (!v2_ff || !rsp_stall);
   assign req_stall = v1_ff && !adv;

   assign full         = count_ff == CNT_W'(DEPTH);
   assign in_ins_range = r1_ff.position <= 5'(count_ff);
   assign in_rd_range  = r1_ff.position < 5'(count_ff);

   assign wide_in = {32'b0, r1_ff.word_in};
   assign wr_word = wide_in[DATA_WIDTH-1:0];

   always_comb begin
      cmd.ins = 1'b0;
      cmd.del = 1'b0;
      cmd.idx = r1_ff.position[IDX_W-1:0];
      rd_ok   = 1'b0;
      status  = ST_OK;
      unique case (r1_ff.action)
         ACT_APPEND: begin
            cmd.idx = count_ff[IDX_W-1:0];
            if (full) begin
               status = ST_FULL;
            end else begin
               cmd.ins = 1'b1;
            end
         end
         ACT_PREPEND: begin
            cmd.idx = '0;
            if (full) begin
               status = ST_FULL;
            end else begin
               cmd.ins = 1'b1;
            end
         end
         ACT_INSERT: begin
            priority if (!in_ins_range) begin
               status = ST_BOUNDS;
            end else if (full) begin
               status = ST_FULL;
            end else begin
               cmd.ins = 1'b1;
            end
         end
         ACT_REMOVE: begin
            if (!in_rd_range) begin
               status = ST_BOUNDS;
            end else begin
               cmd.del = 1'b1;
            end
         end
         ACT_READ: begin
            if (!in_rd_range) begin
               status = ST_BOUNDS;
            end else begin
               rd_ok = 1'b1;
            end
         end
         default: begin
         end
      endcase
      cmd.ins = cmd.ins && adv;
      cmd.del = cmd.del && adv;
   end

   iss_entries #(
      .DATA_WIDTH(DATA_WIDTH)
   ) u_entries (
      .clock  (clock),
      .cmd    (cmd),
      .wr_word(wr_word),
      .rd_idx (r1_ff.position[IDX_W-1:0]),
      .rd_word(rd_word)
   );

   assign rd_wide = 64'(signed'(rd_word));

   always_comb begin
      count_in = count_ff;
      if (cmd.ins) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.del) begin
         count_in = count_ff - CNT_W'(1);
      end
      r2_in.word_out = rd_ok ? rd_wide[31:0] : 32'sd0;
      r2_in.status   = status;
      r2_in.length   = 5'(count_in);
   end

   assign v1_in = req_stall ? 1'b1 : req_valid;

   always_comb begin
      v2_in = v2_ff;
      if (adv) begin
         v2_in = 1'b1;
      end else if (!rsp_stall) begin
         v2_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         count_ff <= '0;
      end else begin
         v1_ff    <= v1_in;
         v2_ff    <= v2_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         r1_ff <= req_data;
      end
      if (adv) begin
         r2_ff <= r2_in;
      end
   end

   assign rsp_valid = v2_ff;
   assign rsp_data  = r2_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above depth");

   a_full_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_FULL |-> rsp_data.length == 5'(DEPTH))
      else $error("full status with store not full");

   a_ins_count: assert property (@(posedge clock) disable iff (reset)
      cmd.ins |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("insert did not advance count");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_OK |-> rsp_data.word_out == 32'sd0)
      else $error("data word on failed transfer");

endmodule
